// ----- src/sfrc_pkg.sv -----
// Shared types and constants for the sync frame receive checker.
// No dependencies.
package sfrc_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LenWidth    = 16;
   localparam int unsigned ErrWidth    = 2;
   localparam int unsigned CsrIdxWidth = 8;

   localparam logic [ByteWidth-1:0] SYNC_BYTE     = 8'hFF;
   localparam logic [ByteWidth-1:0] LOCAL_ID_RST  = 8'd1;
   localparam logic [ByteWidth-1:0] PEER_ID_RST   = 8'd0;
   localparam logic [8:0]           MOD_BASE      = 9'd255;

   localparam logic [CsrIdxWidth-1:0] CSR_LOCAL_ID = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PEER_ID  = 8'd1;

   localparam logic [ErrWidth-1:0] ERR_NONE     = 2'd0;
   localparam logic [ErrWidth-1:0] ERR_SENDER   = 2'd1;
   localparam logic [ErrWidth-1:0] ERR_RECEIVER = 2'd2;
   localparam logic [ErrWidth-1:0] ERR_CHECKSUM = 2'd3;

   typedef struct packed {
      logic                 payload_valid;
      logic [ByteWidth-1:0] payload_byte;
      logic [LenWidth-1:0]  payload_index;
      logic                 frame_good;
      logic [LenWidth-1:0]  frame_length;
      logic [ErrWidth-1:0]  error_code;
   } result_type;

endpackage

// ----- src/sync_frame_receive_checker_core.sv -----
// Sync frame receive checker: frame parser, id match, mod-255 checksum.
// Depends on sfrc_pkg.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_rx_byte
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_payload_*, rsp_frame_*, rsp_error_code
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One item per cycle while req_stall is low; each item's result is registered in the result register,
// or in the one-entry skid register behind it, which keeps input flowing
// for one more item while the result side stalls; req_stall rises once it fills.
// Reset is synchronous; it clears parser state and output valid flags and loads the id defaults.
module sync_frame_receive_checker_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sfrc_pkg::ByteWidth-1:0]        req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_payload_valid,
   output logic [sfrc_pkg::ByteWidth-1:0]        rsp_payload_byte,
   output logic [sfrc_pkg::LenWidth-1:0]         rsp_payload_index,
   output logic                                  rsp_frame_good,
   output logic [sfrc_pkg::LenWidth-1:0]         rsp_frame_length,
   output logic [sfrc_pkg::ErrWidth-1:0]         rsp_error_code,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sfrc_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [sfrc_pkg::ByteWidth-1:0]        csr_data
);

   localparam logic [2:0] PH_SYNC1    = 3'd0;
   localparam logic [2:0] PH_SYNC2    = 3'd1;
   localparam logic [2:0] PH_SENDER   = 3'd2;
   localparam logic [2:0] PH_RECEIVER = 3'd3;
   localparam logic [2:0] PH_LEN_HI   = 3'd4;
   localparam logic [2:0] PH_LEN_LO   = 3'd5;
   localparam logic [2:0] PH_PAYLOAD  = 3'd6;
   localparam logic [2:0] PH_CHECK    = 3'd7;

   logic [2:0]                      phase_ff, phase_in;
   logic [sfrc_pkg::ByteWidth-1:0]  sum_ff, sum_in;
   logic [sfrc_pkg::LenWidth-1:0]   exp_len_ff, exp_len_in;
   logic [sfrc_pkg::LenWidth-1:0]   taken_ff, taken_in;
   logic [sfrc_pkg::ByteWidth-1:0]  local_id_ff, peer_id_ff;

   sfrc_pkg::result_type            res_in, main_ff, skid_ff;
   logic                            main_valid_ff, skid_valid_ff;

   logic                            accept, out_take, main_free;
   logic [8:0]                      raw_sum;
   logic [sfrc_pkg::ByteWidth-1:0]  sum_add;
   logic [sfrc_pkg::LenWidth:0]     taken_next;

   assign accept    = req_valid & ~skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_take  = main_valid_ff & ~rsp_stall;
   assign main_free = ~main_valid_ff | out_take;
   assign csr_ready = 1'b1;

   assign raw_sum = {1'b0, sum_ff} + {1'b0, req_rx_byte};
   assign sum_add = (raw_sum >= sfrc_pkg::MOD_BASE) ?
                    8'(raw_sum - sfrc_pkg::MOD_BASE) : raw_sum[7:0];
   assign taken_next = {1'b0, taken_ff} + 17'd1;

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      exp_len_in = exp_len_ff;
      taken_in   = taken_ff;
      res_in     = '0;
      case (phase_ff)
         PH_SYNC1: begin
            if (req_rx_byte == sfrc_pkg::SYNC_BYTE) begin
               // 0xFF mod 255 is zero
               sum_in     = '0;
               exp_len_in = '0;
               taken_in   = '0;
               phase_in   = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (req_rx_byte == sfrc_pkg::SYNC_BYTE) begin
               sum_in   = sum_add;
               phase_in = PH_SENDER;
            end else begin
               phase_in = PH_SYNC1;
            end
         end
         PH_SENDER: begin
            if (req_rx_byte == peer_id_ff) begin
               sum_in   = sum_add;
               phase_in = PH_RECEIVER;
            end else begin
               res_in.error_code = sfrc_pkg::ERR_SENDER;
               phase_in          = PH_SYNC1;
            end
         end
         PH_RECEIVER: begin
            if (req_rx_byte == local_id_ff) begin
               sum_in   = sum_add;
               phase_in = PH_LEN_HI;
            end else begin
               res_in.error_code = sfrc_pkg::ERR_RECEIVER;
               phase_in          = PH_SYNC1;
            end
         end
         PH_LEN_HI: begin
            sum_in     = sum_add;
            exp_len_in = {req_rx_byte, 8'h00};
            phase_in   = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            sum_in     = sum_add;
            exp_len_in = {exp_len_ff[15:8], req_rx_byte};
            taken_in   = '0;
            phase_in   = ({exp_len_ff[15:8], req_rx_byte} == 16'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            sum_in               = sum_add;
            res_in.payload_valid = 1'b1;
            res_in.payload_byte  = req_rx_byte;
            res_in.payload_index = taken_ff;
            taken_in             = taken_next[15:0];
            if (taken_next >= {1'b0, exp_len_ff}) begin
               phase_in = PH_CHECK;
            end
         end
         default: begin
            if (req_rx_byte == sum_ff) begin
               res_in.frame_good   = 1'b1;
               res_in.frame_length = exp_len_ff;
            end else begin
               res_in.error_code = sfrc_pkg::ERR_CHECKSUM;
            end
            sum_in   = '0;
            phase_in = PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         sum_ff     <= '0;
         exp_len_ff <= '0;
         taken_ff   <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         sum_ff     <= sum_in;
         exp_len_ff <= exp_len_in;
         taken_ff   <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff <= sfrc_pkg::LOCAL_ID_RST;
         peer_id_ff  <= sfrc_pkg::PEER_ID_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == sfrc_pkg::CSR_LOCAL_ID) begin
            local_id_ff <= csr_data;
         end else if (csr_index == sfrc_pkg::CSR_PEER_ID) begin
            peer_id_ff <= csr_data;
         end
      end
   end

   // result register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (accept) begin
            main_ff <= res_in;
         end
      end else if (accept) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid         = main_valid_ff;
   assign rsp_payload_valid = main_ff.payload_valid;
   assign rsp_payload_byte  = main_ff.payload_byte;
   assign rsp_payload_index = main_ff.payload_index;
   assign rsp_frame_good    = main_ff.frame_good;
   assign rsp_frame_length  = main_ff.frame_length;
   assign rsp_error_code    = main_ff.error_code;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for sync_frame_receive_checker_core: directed and random byte streams checked
// against a frame parser kept in the bench (sync hunt, id match, mod-255 checksum, payload).
// Depends on sfrc_pkg and sync_frame_receive_checker_core.
module tb;

   typedef enum logic [2:0] {
      HUNT_SYNC1, HUNT_SYNC2, GET_SENDER, GET_RECEIVER,
      GET_LEN_HI, GET_LEN_LO, GET_PAYLOAD, GET_CHECK
   } parse_phase_type;

   localparam logic [sfrc_pkg::CsrIdxWidth-1:0] CSR_SPARE = 8'd2;
   localparam logic [sfrc_pkg::CsrIdxWidth-1:0] CSR_TOP   = 8'hFF;
   localparam int IdleLimit  = 5000;
   localparam int LongHold   = 80;
   localparam int PhaseItems = 50;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   logic [sfrc_pkg::ByteWidth-1:0]   req_rx_byte = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   logic                             rsp_payload_valid;
   logic [sfrc_pkg::ByteWidth-1:0]   rsp_payload_byte;
   logic [sfrc_pkg::LenWidth-1:0]    rsp_payload_index;
   logic                             rsp_frame_good;
   logic [sfrc_pkg::LenWidth-1:0]    rsp_frame_length;
   logic [sfrc_pkg::ErrWidth-1:0]    rsp_error_code;
   logic                             csr_valid   = 1'b0;
   logic                             csr_ready;
   logic [sfrc_pkg::CsrIdxWidth-1:0] csr_index   = '0;
   logic [sfrc_pkg::ByteWidth-1:0]   csr_data    = '0;

   // bench copy of the parser state and id registers
   logic [sfrc_pkg::ByteWidth-1:0]   local_id_m  = sfrc_pkg::LOCAL_ID_RST;
   logic [sfrc_pkg::ByteWidth-1:0]   peer_id_m   = sfrc_pkg::PEER_ID_RST;
   parse_phase_type                  phase_m     = HUNT_SYNC1;
   logic [sfrc_pkg::ByteWidth-1:0]   csum_m      = '0;
   logic [sfrc_pkg::LenWidth-1:0]    len_m       = '0;
   logic [sfrc_pkg::LenWidth-1:0]    taken_m     = '0;

   logic [sfrc_pkg::ByteWidth-1:0]   pending_bytes[$];
   sfrc_pkg::result_type             parse_results[$];

   bit gaps_on = 1'b1;
   int hold_requests = 0;
   int holds_done    = 0;
   int send_gap      = 0;
   int stall_left    = 0;
   int idle_cycles   = 0;
   int items_queued  = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int good_frames   = 0;
   int mismatches    = 0;
   int err_count[4]  = '{default: 0};

   sync_frame_receive_checker_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_error_code    (rsp_error_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [sfrc_pkg::ByteWidth-1:0] add_mod255(
      logic [sfrc_pkg::ByteWidth-1:0] a, logic [sfrc_pkg::ByteWidth-1:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= sfrc_pkg::MOD_BASE) begin
         s = s - sfrc_pkg::MOD_BASE;
      end
      return s[sfrc_pkg::ByteWidth-1:0];
   endfunction

   function automatic sfrc_pkg::result_type parse_byte(logic [sfrc_pkg::ByteWidth-1:0] b);
      sfrc_pkg::result_type r;
      r = '0;
      case (phase_m)
         HUNT_SYNC1: begin
            if (b == sfrc_pkg::SYNC_BYTE) begin
               csum_m  = add_mod255('0, b);
               len_m   = '0;
               taken_m = '0;
               phase_m = HUNT_SYNC2;
            end
         end
         HUNT_SYNC2: begin
            if (b == sfrc_pkg::SYNC_BYTE) begin
               csum_m  = add_mod255(csum_m, b);
               phase_m = GET_SENDER;
            end else begin
               phase_m = HUNT_SYNC1;
            end
         end
         GET_SENDER: begin
            if (b == peer_id_m) begin
               csum_m  = add_mod255(csum_m, b);
               phase_m = GET_RECEIVER;
            end else begin
               r.error_code = sfrc_pkg::ERR_SENDER;
               phase_m = HUNT_SYNC1;
            end
         end
         GET_RECEIVER: begin
            if (b == local_id_m) begin
               csum_m  = add_mod255(csum_m, b);
               phase_m = GET_LEN_HI;
            end else begin
               r.error_code = sfrc_pkg::ERR_RECEIVER;
               phase_m = HUNT_SYNC1;
            end
         end
         GET_LEN_HI: begin
            csum_m  = add_mod255(csum_m, b);
            len_m   = {b, 8'h00};
            phase_m = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            csum_m  = add_mod255(csum_m, b);
            len_m   = len_m | {8'h00, b};
            taken_m = '0;
            phase_m = (len_m == '0) ? GET_CHECK : GET_PAYLOAD;
         end
         GET_PAYLOAD: begin
            csum_m          = add_mod255(csum_m, b);
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = taken_m;
            taken_m         = taken_m + 1'b1;
            if (taken_m >= len_m) begin
               phase_m = GET_CHECK;
            end
         end
         default: begin
            if (b == csum_m) begin
               r.frame_good   = 1'b1;
               r.frame_length = len_m;
            end else begin
               r.error_code = sfrc_pkg::ERR_CHECKSUM;
            end
            csum_m  = '0;
            phase_m = HUNT_SYNC1;
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void send_byte(logic [sfrc_pkg::ByteWidth-1:0] b);
      pending_bytes.push_back(b);
      items_queued++;
   endfunction

   // whole frame with correct or corrupted checksum; the first skip bytes are not queued
   function automatic void queue_frame(logic [sfrc_pkg::ByteWidth-1:0] sender,
                                       logic [sfrc_pkg::ByteWidth-1:0] receiver,
                                       logic [sfrc_pkg::LenWidth-1:0] len, bit bad_sum,
                                       int skip);
      logic [sfrc_pkg::ByteWidth-1:0] frame[$];
      logic [sfrc_pkg::ByteWidth-1:0] csum;
      frame = {sfrc_pkg::SYNC_BYTE, sfrc_pkg::SYNC_BYTE, sender, receiver,
               len[15:8], len[7:0]};
      for (int i = 0; i < len; i++) begin
         frame.push_back(8'($urandom_range(0, 255)));
      end
      csum = '0;
      foreach (frame[i]) begin
         csum = add_mod255(csum, frame[i]);
      end
      if (bad_sum) begin
         csum = csum ^ (8'd1 << $urandom_range(0, 7));
      end
      frame.push_back(csum);
      for (int i = skip; i < frame.size(); i++) begin
         send_byte(frame[i]);
      end
   endfunction

   function automatic void queue_random_traffic(int target);
      int pick;
      logic [sfrc_pkg::LenWidth-1:0] len;
      while (items_queued < target) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 40))
                                            : 16'($urandom_range(0, 8));
         if (pick < 72) begin
            queue_frame(peer_id_m, local_id_m, len, 1'b0, 0);
         end else if (pick < 82) begin
            queue_frame(peer_id_m, local_id_m, len, 1'b1, 0);
         end else if (pick < 88) begin
            send_byte(sfrc_pkg::SYNC_BYTE);
            send_byte(sfrc_pkg::SYNC_BYTE);
            send_byte(peer_id_m ^ 8'($urandom_range(1, 255)));
         end else if (pick < 94) begin
            send_byte(sfrc_pkg::SYNC_BYTE);
            send_byte(sfrc_pkg::SYNC_BYTE);
            send_byte(peer_id_m);
            send_byte(local_id_m ^ 8'($urandom_range(1, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || parse_results.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(logic [sfrc_pkg::CsrIdxWidth-1:0] idx,
                            logic [sfrc_pkg::ByteWidth-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == sfrc_pkg::CSR_LOCAL_ID) begin
         local_id_m = data;
      end else if (idx == sfrc_pkg::CSR_PEER_ID) begin
         peer_id_m = data;
      end
   endtask

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_results.push_back(parse_byte(req_rx_byte));
            items_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_bytes.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
               send_gap    <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      int next;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         stall_left <= LongHold - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         next = pick_gap();
         rsp_stall  <= (next > 0);
         stall_left <= (next > 0) ? next - 1 : 0;
      end
   end

   // result monitor
   always @(posedge clock) begin
      sfrc_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         err_count[rsp_error_code]++;
         if (rsp_frame_good) begin
            good_frames++;
         end
         if (parse_results.size() == 0) begin
            $display("%0t: unexpected item, expected none actual error_code %0h", $time,
                     rsp_error_code);
            mismatches++;
         end else begin
            want = parse_results.pop_front();
            check_field("payload_valid", want.payload_valid, rsp_payload_valid);
            check_field("payload_byte", want.payload_byte, rsp_payload_byte);
            check_field("payload_index", want.payload_index, rsp_payload_index);
            check_field("frame_good", want.frame_good, rsp_frame_good);
            check_field("frame_length", want.frame_length, rsp_frame_length);
            check_field("error_code", want.error_code, rsp_error_code);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("%0t: no progress for %0d cycles", $time, IdleLimit);
         $display("sync_frame_receive_checker_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [sfrc_pkg::ByteWidth-1:0] loc_set[6];
      logic [sfrc_pkg::ByteWidth-1:0] peer_set[6];
      logic [sfrc_pkg::ByteWidth-1:0] old_peer;
      bit carry;
      loc_set  = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h80,
                   8'($urandom_range(0, 255)), sfrc_pkg::LOCAL_ID_RST};
      peer_set = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h7F,
                   8'($urandom_range(0, 255)), sfrc_pkg::PEER_ID_RST};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero length, bad second sync, id mismatches, bad checksum
      queue_frame(peer_id_m, local_id_m, 16'd0, 1'b0, 0);
      send_byte(sfrc_pkg::SYNC_BYTE);
      send_byte(8'h12);
      send_byte(sfrc_pkg::SYNC_BYTE);
      send_byte(sfrc_pkg::SYNC_BYTE);
      send_byte(8'h55);
      send_byte(sfrc_pkg::SYNC_BYTE);
      send_byte(sfrc_pkg::SYNC_BYTE);
      send_byte(peer_id_m);
      send_byte(8'hAA);
      send_byte(sfrc_pkg::SYNC_BYTE);
      send_byte(sfrc_pkg::SYNC_BYTE);
      send_byte(peer_id_m);
      send_byte(local_id_m);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sfrc_pkg::SYNC_BYTE);  // a mod-255 sum never reaches 0xFF
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         carry    = (p % 2 == 1);
         old_peer = peer_id_m;
         // leave a frame open across the id change
         if (carry) begin
            send_byte(sfrc_pkg::SYNC_BYTE);
            send_byte(sfrc_pkg::SYNC_BYTE);
            send_byte(old_peer);
            wait_drained();
         end
         if (p == 0 || p == 4) begin
            write_csr(CSR_SPARE, 8'($urandom_range(0, 255)));
            write_csr(CSR_TOP, 8'($urandom_range(0, 255)));
         end
         write_csr(sfrc_pkg::CSR_LOCAL_ID, loc_set[p]);
         write_csr(sfrc_pkg::CSR_PEER_ID, peer_set[p]);
         @(negedge clock);
         items_queued = 0;
         gaps_on = (p != 2 && p != 5);
         if (p == 2) begin
            hold_requests++;
         end
         if (carry) begin
            queue_frame(old_peer, local_id_m, 16'($urandom_range(0, 6)), 1'b0, 3);
         end
         if (p == 3) begin
            queue_frame(peer_id_m, local_id_m, 16'd300, 1'b0, 0);
         end
         queue_random_traffic(PhaseItems);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (parse_results.size() != 0) begin
         $display("%0t: %0d results expected, actual none", $time, parse_results.size());
         mismatches++;
      end
      $display("%0d bytes in, %0d items out over 7 id settings, %0d good frames", items_sent,
               results_seen, good_frames);
      $display("errors seen: sender %0d, receiver %0d, checksum %0d; %0d mismatches",
               err_count[sfrc_pkg::ERR_SENDER], err_count[sfrc_pkg::ERR_RECEIVER],
               err_count[sfrc_pkg::ERR_CHECKSUM], mismatches);
      if (mismatches == 0) begin
         $display("sync_frame_receive_checker_core regression: pass");
      end else begin
         $display("sync_frame_receive_checker_core regression: fail");
      end
      $finish;
   end

endmodule

// ----- sync_frame_receive_checker_core.f -----
src/sfrc_pkg.sv
src/sync_frame_receive_checker_core.sv
dv/tb.sv
